[sv/ctwa_pkg.sv]
// shared types and constants for the connection table with aging
package ctwa_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int KEY_W   = 2 * ADDR_W + 2 * PORT_W;
  localparam int TIME_W  = 32;
  localparam int IVL_W   = 16;
  localparam int CNT_W   = 9;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [PORT_W-1:0]  PORT_MASK = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd1000;
  localparam logic [IVL_W-1:0]  INTERVAL_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIFETIME = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_ERASE  = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_INSERT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic scan_rd;
    logic insert;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic scan_needed;
    logic is_add;
  } stat_t;

endpackage

[sv/ctwa_in_if.sv]
// request channel interface
interface ctwa_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [ctwa_pkg::ADDR_W-1:0]   src_addr;
  logic [ctwa_pkg::ADDR_W-1:0]   dst_addr;
  logic [ctwa_pkg::PORT_W-1:0]   src_port;
  logic [ctwa_pkg::PORT_W-1:0]   dst_port;
  logic [ctwa_pkg::ADDR_W-1:0]   src_mask;
  logic [ctwa_pkg::ADDR_W-1:0]   dst_mask;
  logic                          src_port_any;
  logic                          dst_port_any;

  modport source (output valid, func, src_addr, dst_addr, src_port, dst_port,
                  src_mask, dst_mask, src_port_any, dst_port_any, input ready);
  modport sink (input valid, func, src_addr, dst_addr, src_port, dst_port,
                src_mask, dst_mask, src_port_any, dst_port_any, output ready);
endinterface

[sv/ctwa_out_if.sv]
// result channel interface
interface ctwa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [ctwa_pkg::CNT_W-1:0]  removed_count;

  modport source (output valid, success, removed_count, input ready);
  modport sink (input valid, success, removed_count, output ready);
endinterface

[sv/ctwa_ctrl.sv]
// controller state machine for the table scan sequence
module ctwa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ctwa_pkg::stat_t  stat,
  output ctwa_pkg::cmd_t   cmd
);
  import ctwa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_finish;

  assign can_finish = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.idx_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = stat.scan_needed ? S_SCAN : S_DONE;
      S_SCAN:   if (stat.idx_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = stat.is_add ? S_INSERT : S_DONE;
      S_INSERT: state_nxt = S_DONE;
      S_DONE:   if (can_finish) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clear_wr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:   cmd.scan_rd = 1'b1;
      S_INSERT: cmd.insert = 1'b1;
      S_DONE:   cmd.finish = can_finish;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[sv/ctwa_dp.sv]
// datapath: entry memory, scan pipeline, time base and result registers
module ctwa_dp #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ctwa_pkg::cmd_t                    cmd,
  output ctwa_pkg::stat_t                   stat,
  input  logic [1:0]                        in_func,
  input  logic [ctwa_pkg::ADDR_W-1:0]       in_src_addr,
  input  logic [ctwa_pkg::ADDR_W-1:0]       in_dst_addr,
  input  logic [ctwa_pkg::PORT_W-1:0]       in_src_port,
  input  logic [ctwa_pkg::PORT_W-1:0]       in_dst_port,
  input  logic [ctwa_pkg::ADDR_W-1:0]       in_src_mask,
  input  logic [ctwa_pkg::ADDR_W-1:0]       in_dst_mask,
  input  logic                              in_src_port_any,
  input  logic                              in_dst_port_any,
  input  logic                              cfg_we,
  input  logic [ctwa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctwa_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_success,
  output logic [ctwa_pkg::CNT_W-1:0]        out_removed_count
);
  import ctwa_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];

  // request registers
  func_t             func_r;
  logic [KEY_W-1:0]  key_r;
  logic [ADDR_W-1:0] smask_r;
  logic [ADDR_W-1:0] dmask_r;
  logic [2*PORT_W-1:0] pmask_r;
  logic [TIME_W-1:0] fresh_r;
  logic              scan_needed_r;

  // time base and configuration
  logic [TIME_W-1:0] time_r;
  logic [IVL_W-1:0]  countdown_r;
  logic [TIME_W-1:0] lifetime_r;
  logic [IVL_W-1:0]  interval_r;

  // scan pipeline
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  proc_idx_r;
  logic              rd_vld_r;
  entry_t            rd_data_r;

  // per-request accumulators
  logic              found_r, found_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt, removed_inc;
  logic              success_r, success_nxt;

  logic              out_success_r;
  logic [CNT_W-1:0]  out_removed_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              key_hit, rule_hit, aged;
  logic [TIME_W:0]   expiry_sum;
  logic              sweep_due;

  assign expiry_sum = {1'b0, time_r} + {1'b0, lifetime_r};
  assign sweep_due  = (countdown_r <= IVL_W'(1));

  assign key_hit  = rd_data_r.valid && (rd_data_r.key == key_r);
  assign rule_hit = rd_data_r.valid
    && ((key_r[KEY_W-1 -: ADDR_W] & smask_r) == (rd_data_r.key[KEY_W-1 -: ADDR_W] & smask_r))
    && ((key_r[2*PORT_W +: ADDR_W] & dmask_r) == (rd_data_r.key[2*PORT_W +: ADDR_W] & dmask_r))
    && ((key_r[2*PORT_W-1:0] & pmask_r) == (rd_data_r.key[2*PORT_W-1:0] & pmask_r));
  assign aged = rd_data_r.valid && (rd_data_r.expiry <= time_r);

  assign removed_inc = (removed_r == CNT_MAX) ? removed_r : removed_r + 1'b1;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clear_wr || cmd.scan_rd) begin
      idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    end
  end

  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = proc_idx_r;
    wr_data        = rd_data_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    removed_nxt    = removed_r;
    success_nxt    = success_r;
    if (cmd.load) begin
      found_nxt      = 1'b0;
      free_found_nxt = 1'b0;
      removed_nxt    = '0;
      success_nxt    = 1'b0;
    end else if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = '0;
    end else if (cmd.insert) begin
      if (!found_r && free_found_r) begin
        wr_en          = 1'b1;
        wr_addr        = free_idx_r;
        wr_data.valid  = 1'b1;
        wr_data.key    = key_r;
        wr_data.expiry = fresh_r;
        success_nxt    = 1'b1;
      end
    end else if (rd_vld_r) begin
      unique case (func_r)
        FUNC_LOOKUP: begin
          if (key_hit && !found_r) begin
            wr_en          = 1'b1;
            wr_data.expiry = fresh_r;
            found_nxt      = 1'b1;
            success_nxt    = 1'b1;
          end
        end
        FUNC_ADD: begin
          if (key_hit) found_nxt = 1'b1;
          // lowest free slot wins
          if (!rd_data_r.valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = proc_idx_r;
          end
        end
        FUNC_ERASE: begin
          if (rule_hit) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
            removed_nxt   = removed_inc;
          end
        end
        FUNC_TICK: begin
          if (aged) begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
            removed_nxt   = removed_inc;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.scan_rd) rd_data_r <= mem[idx_r];
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func_t'(in_func);
      key_r   <= {in_src_addr, in_dst_addr, in_src_port, in_dst_port};
      smask_r <= in_src_mask;
      dmask_r <= in_dst_mask;
      pmask_r <= {in_src_port_any ? '0 : PORT_MASK, in_dst_port_any ? '0 : PORT_MASK};
      fresh_r <= expiry_sum[TIME_W] ? TIME_MAX : expiry_sum[TIME_W-1:0];
    end
    if (cmd.scan_rd) proc_idx_r <= idx_r;
    free_idx_r <= free_idx_nxt;
    if (cmd.finish) begin
      out_success_r <= success_r;
      out_removed_r <= removed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      rd_vld_r      <= 1'b0;
      time_r        <= '0;
      countdown_r   <= '0;
      lifetime_r    <= LIFETIME_RST;
      interval_r    <= INTERVAL_RST;
      scan_needed_r <= 1'b0;
      found_r       <= 1'b0;
      free_found_r  <= 1'b0;
      removed_r     <= '0;
      success_r     <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      rd_vld_r     <= cmd.scan_rd;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      removed_r    <= removed_nxt;
      success_r    <= success_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LIFETIME: lifetime_r <= cfg_data[TIME_W-1:0];
          CFG_INTERVAL: interval_r <= cfg_data[IVL_W-1:0];
          default:      lifetime_r <= lifetime_r;
        endcase
      end
      if (cmd.load) begin
        scan_needed_r <= (func_t'(in_func) != FUNC_TICK) || sweep_due;
        if (func_t'(in_func) == FUNC_TICK) begin
          time_r <= time_r + 1'b1;
          if (sweep_due) begin
            countdown_r <= (interval_r == '0) ? IVL_W'(1) : interval_r;
          end else begin
            countdown_r <= countdown_r - 1'b1;
          end
        end
      end
    end
  end

  assign stat.idx_last    = (idx_r == LAST_IDX);
  assign stat.scan_needed = scan_needed_r;
  assign stat.is_add      = (func_r == FUNC_ADD);

  assign out_success       = out_success_r;
  assign out_removed_count = out_removed_r;
endmodule

[sv/connection_table_with_aging_core.sv]
// top level of the connection table with aging
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    func, addresses, ports, masks, port wildcards
//  out_ch   out  valid/ready    success, removed_count
//  cfg_*    in   cfg_we only    cfg_index selects lifetime or sweep interval
//
// lookup, add, erase and a sweeping tick walk the entry memory one slot per
// cycle through its single read port, and an add then takes an insert step;
// a tick with no sweep due skips the walk
// after reset a clearing pass over every slot zeroes the memory and
// in_ch.ready stays low; cfg writes are taken at any time
// a finished result waits in the output register; a new request is accepted
// meanwhile, and its result waits in the datapath until the register frees
module connection_table_with_aging_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ctwa_in_if.sink                           in_ch,
  ctwa_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ctwa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctwa_pkg::CFG_W-1:0]        cfg_data
);
  import ctwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  // sequencing: clearing pass, accept, scan, drain, optional insert, deliver
  ctwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry memory, match logic, time base and result register
  ctwa_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_ch.func),
    .in_src_addr       (in_ch.src_addr),
    .in_dst_addr       (in_ch.dst_addr),
    .in_src_port       (in_ch.src_port),
    .in_dst_port       (in_ch.dst_port),
    .in_src_mask       (in_ch.src_mask),
    .in_dst_mask       (in_ch.dst_mask),
    .in_src_port_any   (in_ch.src_port_any),
    .in_dst_port_any   (in_ch.dst_port_any),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_success       (out_ch.success),
    .out_removed_count (out_ch.removed_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
endmodule

[sv/ctwa_checker.sv]
// port-level assertions for the connection table core and their bind
module ctwa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_success,
  input logic [ctwa_pkg::CNT_W-1:0]  out_removed_count
);
  import ctwa_pkg::*;

  // reset starts the clearing pass with no request taken and no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!in_ready && !out_valid))
    else $error("ready or result right after reset");

  // one request at a time: the block goes busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the previous one is in progress");

  // a successful lookup or add never reports removals
  a_success_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_success) |-> (out_removed_count == '0))
    else $error("success together with a removal count");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_success) && $stable(out_removed_count)))
    else $error("pending result dropped or changed");
endmodule

bind connection_table_with_aging_core ctwa_checker u_ctwa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_success       (out_ch.success),
  .out_removed_count (out_ch.removed_count)
);

[sim/testbench.sv]
// self-checking testbench for the connection table with aging: shadow table predictor, random traffic
`timescale 1ns / 1ps

module testbench;
  import ctwa_pkg::*;

  localparam int TABLE_ENTRIES  = 256;
  // room for a sweeping request to walk every slot once, with margin
  localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 16;
  // longest quiet stretch of a correct run is the long receiver hold-off
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 1500;

  // one request as it is offered on the input channel
  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [ADDR_W-1:0] src_mask;
    logic [ADDR_W-1:0] dst_mask;
    logic              src_port_any;
    logic              dst_port_any;
  } table_request_t;

  typedef struct packed {
    logic             success;
    logic [CNT_W-1:0] removed_count;
  } table_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  ctwa_in_if  in_ch ();
  ctwa_out_if out_ch ();

  connection_table_with_aging_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the connection table
  bit                conn_valid  [TABLE_ENTRIES];
  logic [KEY_W-1:0]  conn_key    [TABLE_ENTRIES];
  logic [TIME_W-1:0] conn_expiry [TABLE_ENTRIES];
  logic [TIME_W-1:0] now_ticks        = '0;
  logic [IVL_W-1:0]  sweep_wait       = '0;
  logic [TIME_W-1:0] lifetime_setting = LIFETIME_RST;
  logic [IVL_W-1:0]  interval_setting = INTERVAL_RST;

  // results still owed by the block, oldest first
  table_result_t     pending_results[$];
  int                mismatch_count = 0;
  int                stalled_cycles = 0;

  // knobs shared by the stimulus and the two channel drivers
  bit                steady_flow      = 1'b0;
  int                sink_hold_cycles = 0;
  logic [KEY_W-1:0]  key_pool[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // key layout: src addr, dst addr, src port, dst port from msb down
  function automatic int find_connection(input logic [KEY_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (conn_valid[i] && conn_key[i] == key) return i;
    end
    return -1;
  endfunction

  // now plus lifetime, pinned at the top of the time range on overflow
  function automatic logic [TIME_W-1:0] fresh_expiry();
    logic [TIME_W:0] sum;
    sum = {1'b0, now_ticks} + {1'b0, lifetime_setting};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic table_result_t predict_table_op(input table_request_t r);
    table_result_t    res;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] care;
    int               hit;
    int               removed;
    res     = '0;
    removed = 0;
    key     = {r.src_addr, r.dst_addr, r.src_port, r.dst_port};
    case (r.func)
      FUNC_LOOKUP: begin
        // a hit refreshes the expiry, even on an entry that is already stale
        hit = find_connection(key);
        if (hit >= 0) begin
          conn_expiry[hit] = fresh_expiry();
          res.success      = 1'b1;
        end
      end
      FUNC_ADD: begin
        // lowest free slot; refused on a duplicate key or a full table
        if (find_connection(key) < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!conn_valid[i]) begin
              conn_valid[i]  = 1'b1;
              conn_key[i]    = key;
              conn_expiry[i] = fresh_expiry();
              res.success    = 1'b1;
              break;
            end
          end
        end
      end
      FUNC_ERASE: begin
        // masked addresses, ports either compared whole or ignored
        care = {r.src_mask, r.dst_mask, {PORT_W{~r.src_port_any}}, {PORT_W{~r.dst_port_any}}};
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (conn_valid[i] && ((conn_key[i] ^ key) & care) == '0) begin
            conn_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      default: begin
        // tick: time moves on, sweep when the countdown runs out
        now_ticks++;
        if (sweep_wait <= 1) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (conn_valid[i] && conn_expiry[i] <= now_ticks) begin
              conn_valid[i] = 1'b0;
              removed++;
            end
          end
          // a zero interval behaves as one, a sweep on every tick
          sweep_wait = (interval_setting == '0) ? IVL_W'(1) : interval_setting;
        end else begin
          sweep_wait--;
        end
      end
    endcase
    res.removed_count = (removed > CNT_MAX) ? CNT_MAX : CNT_W'(removed);
    return res;
  endfunction

  // ------------------------------------------------------------------
  // scoreboard: check results first, then record the accepted request
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    table_result_t  want;
    table_request_t req;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result success=%0b removed_count=%0d", $time,
                 out_ch.success, out_ch.removed_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.success !== want.success) begin
          $display("%0t: success expected %0b actual %0b", $time, want.success,
                   out_ch.success);
          mismatch_count++;
        end
        if (out_ch.removed_count !== want.removed_count) begin
          $display("%0t: removed_count expected %0d actual %0d", $time,
                   want.removed_count, out_ch.removed_count);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      req.func         = func_t'(in_ch.func);
      req.src_addr     = in_ch.src_addr;
      req.dst_addr     = in_ch.dst_addr;
      req.src_port     = in_ch.src_port;
      req.dst_port     = in_ch.dst_port;
      req.src_mask     = in_ch.src_mask;
      req.dst_mask     = in_ch.dst_mask;
      req.src_port_any = in_ch.src_port_any;
      req.dst_port_any = in_ch.dst_port_any;
      pending_results.push_back(predict_table_op(req));
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // result receiver: random stall per result, or one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // offer one request after a random gap, return at the accepting edge
  // valid stays high so a back-to-back request needs no extra edge
  task automatic send_request(input table_request_t r);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= r.func;
    in_ch.src_addr     <= r.src_addr;
    in_ch.dst_addr     <= r.dst_addr;
    in_ch.src_port     <= r.src_port;
    in_ch.dst_port     <= r.dst_port;
    in_ch.src_mask     <= r.src_mask;
    in_ch.dst_mask     <= r.dst_mask;
    in_ch.src_port_any <= r.src_port_any;
    in_ch.dst_port_any <= r.dst_port_any;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // stop offering and wait until every owed result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // registers change only with the block idle, so the shadow copy follows at once
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIFETIME) lifetime_setting = value[TIME_W-1:0];
    else interval_setting = value[IVL_W-1:0];
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom, $urandom};
  endfunction

  // exact, wildcard, prefix or arbitrary address mask
  function automatic logic [ADDR_W-1:0] random_mask();
    case ($urandom_range(0, 3))
      0: return {ADDR_W{1'b1}};
      1: return {ADDR_W{1'b0}};
      2: return {ADDR_W{1'b1}} << $urandom_range(1, ADDR_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // masks and wildcards are random even where the function ignores them
  function automatic table_request_t build_request(input func_t f,
                                                   input logic [KEY_W-1:0] key);
    table_request_t r;
    r.func = f;
    {r.src_addr, r.dst_addr, r.src_port, r.dst_port} = key;
    r.src_mask     = $urandom;
    r.dst_mask     = $urandom;
    r.src_port_any = 1'($urandom_range(0, 1));
    r.dst_port_any = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_erase(input logic [KEY_W-1:0] key, input logic [ADDR_W-1:0] smask,
                            input logic [ADDR_W-1:0] dmask, input logic sany,
                            input logic dany);
    table_request_t r;
    r              = build_request(FUNC_ERASE, key);
    r.src_mask     = smask;
    r.dst_mask     = dmask;
    r.src_port_any = sany;
    r.dst_port_any = dany;
    send_request(r);
  endtask

  // small pool so lookups hit and adds collide; odd keys share addresses
  // with the previous key and differ only in ports
  function automatic void refill_key_pool(input int n);
    logic [KEY_W-1:0] key;
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      key = random_key();
      if (i % 2 == 1) key[KEY_W-1:2*PORT_W] = key_pool[i-1][KEY_W-1:2*PORT_W];
      key_pool.push_back(key);
    end
  endfunction

  // mostly well-formed traffic on pool keys, some fresh keys as noise
  task automatic run_mixed_traffic(input int count);
    table_request_t   r;
    logic [KEY_W-1:0] key;
    int               pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else key = random_key();
      if (pick < 30) begin
        r = build_request(FUNC_LOOKUP, key);
      end else if (pick < 60) begin
        r = build_request(FUNC_ADD, key);
      end else if (pick < 70) begin
        // erase rule near a known key, sometimes off in the low source bits
        if ($urandom_range(0, 2) == 0) key[KEY_W-1 -: ADDR_W] ^= $urandom_range(0, 255);
        r          = build_request(FUNC_ERASE, key);
        r.src_mask = random_mask();
        r.dst_mask = random_mask();
      end else begin
        r = build_request(FUNC_TICK, key);
      end
      send_request(r);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // field extremes, every function, sweep and expiry corner cases
  task automatic test_directed();
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_zero;
    logic [KEY_W-1:0] k_a;
    logic [KEY_W-1:0] k_b;
    k_ones = '1;
    k_zero = '0;
    k_a    = random_key();
    k_b    = {k_a[KEY_W-1:2*PORT_W], ~k_a[2*PORT_W-1:0]};
    // zero interval before the first tick, so every later tick sweeps
    write_register(CFG_INTERVAL, '0);
    send_request(build_request(FUNC_LOOKUP, k_ones));        // empty table miss
    send_request(build_request(FUNC_ADD, k_ones));
    send_request(build_request(FUNC_ADD, k_ones));           // duplicate refused
    send_request(build_request(FUNC_LOOKUP, k_ones));
    send_request(build_request(FUNC_ADD, k_zero));
    send_request(build_request(FUNC_LOOKUP, k_ones ^ KEY_W'(1))); // near miss in dst port
    send_request(build_request(FUNC_TICK, k_zero));          // first tick sweeps
    send_erase(k_zero, '1, '1, 1'b0, 1'b0);                  // exact rule
    send_request(build_request(FUNC_LOOKUP, k_zero));
    send_request(build_request(FUNC_ADD, k_a));
    send_request(build_request(FUNC_ADD, k_b));
    send_erase(k_a, '1, '1, 1'b1, 1'b1);                     // both ports wildcarded
    send_erase(k_zero, '0, '0, 1'b1, 1'b1);                  // match everything
    send_erase(k_ones, '0, '0, 1'b1, 1'b1);                  // nothing left
    // lifetime set to 1, sweep on every tick
    write_register(CFG_LIFETIME, 32'd1);
    send_request(build_request(FUNC_ADD, k_a));
    send_request(build_request(FUNC_TICK, k_a));
    // interval of three: stale entries linger between sweeps
    write_register(CFG_INTERVAL, 32'd3);
    send_request(build_request(FUNC_ADD, k_a));
    send_request(build_request(FUNC_TICK, k_a));             // sweeps, reloads countdown
    send_request(build_request(FUNC_ADD, k_a));
    send_request(build_request(FUNC_TICK, k_a));
    send_request(build_request(FUNC_TICK, k_a));             // expired, not yet swept
    send_request(build_request(FUNC_ADD, k_a));              // stale key still blocks an add
    send_request(build_request(FUNC_LOOKUP, k_a));           // stale key still hits
    send_request(build_request(FUNC_TICK, k_a));
    // longest lifetime: expiry saturates at the top of the time range
    write_register(CFG_LIFETIME, '1);
    send_request(build_request(FUNC_ADD, k_b));
    send_request(build_request(FUNC_TICK, k_b));
    send_erase(k_b, '0, '0, 1'b1, 1'b1);
  endtask

  // fill every slot, run into a full table, then thin it out and empty it
  task automatic test_table_full();
    logic [KEY_W-1:0] stored[$];
    logic [KEY_W-1:0] key;
    table_request_t   r;
    write_register(CFG_LIFETIME, LIFETIME_RST);
    write_register(CFG_INTERVAL, CFG_W'(INTERVAL_RST));
    repeat (TABLE_ENTRIES + 6) begin
      key = random_key();
      stored.push_back(key);
      send_request(build_request(FUNC_ADD, key));
    end
    repeat (12) send_request(build_request(FUNC_LOOKUP, stored[$urandom_range(0, TABLE_ENTRIES - 1)]));
    repeat (8) send_request(build_request(FUNC_ADD, stored[$urandom_range(0, TABLE_ENTRIES - 1)]));
    repeat (10) begin
      r          = build_request(FUNC_ERASE, stored[$urandom_range(0, stored.size() - 1)]);
      r.src_mask = random_mask();
      r.dst_mask = random_mask();
      send_request(r);
    end
    // refill the freed slots from the bottom
    repeat (6) send_request(build_request(FUNC_ADD, random_key()));
    send_erase(random_key(), '0, '0, 1'b1, 1'b1);
  endtask

  // short lifetimes and intervals so entries age out and sweeps remove them
  task automatic test_aging();
    refill_key_pool(24);
    write_register(CFG_LIFETIME, $urandom_range(1, 40));
    write_register(CFG_INTERVAL, $urandom_range(1, 8));
    run_mixed_traffic(200);
    // stretch with no idling on either side
    steady_flow = 1'b1;
    write_register(CFG_LIFETIME, $urandom_range(2, 12));
    write_register(CFG_INTERVAL, 32'd2);
    run_mixed_traffic(200);
    steady_flow = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the block backs up;
  // then the sender waits for every owed result
  task automatic test_backpressure();
    sink_hold_cycles = LONG_HOLD;
    run_mixed_traffic(30);
    wait_drained();
  endtask

  // several register settings, extremes among them; the widest interval last,
  // since once loaded it stops sweeping for the rest of the run
  task automatic test_random_traffic();
    refill_key_pool(32);
    write_register(CFG_LIFETIME, '0);
    write_register(CFG_INTERVAL, 32'd1);
    run_mixed_traffic(130);
    write_register(CFG_LIFETIME, $urandom);
    write_register(CFG_INTERVAL, $urandom_range(2, 20));
    run_mixed_traffic(130);
    write_register(CFG_LIFETIME, '1);
    write_register(CFG_INTERVAL, 32'd5);
    run_mixed_traffic(130);
    write_register(CFG_LIFETIME, $urandom_range(1, 60));
    write_register(CFG_INTERVAL, 32'd4);
    run_mixed_traffic(130);
    write_register(CFG_INTERVAL, 32'd65535);
    run_mixed_traffic(80);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_LIFETIME;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_LOOKUP;
    in_ch.src_addr     <= '0;
    in_ch.dst_addr     <= '0;
    in_ch.src_port     <= '0;
    in_ch.dst_port     <= '0;
    in_ch.src_mask     <= '0;
    in_ch.dst_mask     <= '0;
    in_ch.src_port_any <= 1'b0;
    in_ch.dst_port_any <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_aging();
    test_backpressure();
    test_random_traffic();

    // all results back, then a window for anything spurious
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
